// ===== rtl/mtks_pkg.sv =====
// Package for the MT19937 keystream byte scrambler.
// Holds generator constants, index type and the twist/temper helper functions.
// No dependencies.
`default_nettype none

package mtks_pkg;

    localparam int STATE_WORDS = 624;
    localparam int TWIST_SHIFT = 397;
    localparam int IDX_W       = $clog2(STATE_WORDS + 1);

    typedef logic [IDX_W-1:0] idx_t;

    localparam idx_t IDX_FULL  = idx_t'(STATE_WORDS);
    localparam idx_t IDX_LAST  = idx_t'(STATE_WORDS - 1);
    localparam idx_t IDX_ONE   = idx_t'(1);
    localparam idx_t FAR_SPLIT = idx_t'(STATE_WORDS - TWIST_SHIFT);
    localparam idx_t FAR_UP    = idx_t'(TWIST_SHIFT);

    localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [31:0] SEED_MULT    = 32'h6C07_8965;
    localparam logic [31:0] SEED_OFFSET  = 32'd6;
    localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;

    localparam logic [7:0] KEY_START   = 8'hC5;
    localparam logic [7:0] STEP_START  = 8'h89;
    localparam logic [7:0] STEP_GROWTH = 8'h49;

    function automatic logic [31:0] twist_one(input logic [31:0] cur,
                                              input logic [31:0] nxt,
                                              input logic [31:0] far);
        logic [31:0] y;
        begin
            y = {cur[31], nxt[30:0]};
            twist_one = far ^ (y >> 1) ^ (nxt[0] ? TWIST_MATRIX : 32'h0);
        end
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        begin
            y = w ^ (w >> 11);
            y = y ^ ((y << 7) & TEMPER_B);
            y = y ^ ((y << 15) & TEMPER_C);
            temper = y ^ (y >> 18);
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mt19937_keystream_byte_scrambler.sv =====
// MT19937 keystream byte scrambler: top level with state memory and sequencer.
// Depends on mtks_pkg.
//
// Usage:
//   Input channel s_valid/s_ready carries s_data_in and s_start_of_table.
//   Result channel m_valid/m_ready carries m_data_out, one item per input.
//   cfg_wr_en/cfg_wr_data write table_length; the seed table_length + 6 is
//   taken when an item with s_start_of_table arrives.
//   Each item lazily twists the one generator word it consumes: two memory
//   reads of the dual-read state RAM, one twist and write, then tempering.
//   A new item is taken only after the previous one has been loaded into
//   the output register. An item with s_start_of_table first reseeds all
//   624 words through the one 32x32 multiplier, a multiply step and an add
//   step for each word after the first.
//   Reset clears control state, the key and step registers and table_length;
//   the state RAM is not cleared and must be seeded before use.
//   When the receiver stalls, the result is held in the output register;
//   one more item may be accepted and carried up to S_OUT, where it waits.
`default_nettype none

module mt19937_keystream_byte_scrambler (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_in,
    input  wire logic        s_start_of_table,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_data_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_MUL,
        S_SEED_ADD,
        S_RD_CN,
        S_RD_F,
        S_TWIST,
        S_OUT
    } state_t;

    state_t             state_reg;
    mtks_pkg::idx_t     idx_reg;
    logic [31:0]        table_length_reg;
    logic [7:0]         key_reg;
    logic [7:0]         step_reg;
    logic [7:0]         byte_reg;
    logic [31:0]        prev_reg;
    logic [31:0]        prod_reg;
    logic [31:0]        cur_reg;
    logic [31:0]        nxt_reg;
    logic [31:0]        word_reg;
    logic               m_valid_reg;
    logic [7:0]         m_data_reg;

    logic [31:0]        mem [mtks_pkg::STATE_WORDS];
    logic [31:0]        rd_a_reg;
    logic [31:0]        rd_b_reg;

    logic               accept;
    logic               mem_we;
    mtks_pkg::idx_t     mem_waddr;
    logic [31:0]        mem_wdata;
    mtks_pkg::idx_t     rd_a_addr;
    mtks_pkg::idx_t     rd_b_addr;
    mtks_pkg::idx_t     idx_nk;
    mtks_pkg::idx_t     idx_fk;
    logic [31:0]        seed_mix;
    logic [31:0]        seed_word;
    logic [31:0]        twisted;
    logic [31:0]        tempered;
    logic               out_free;

    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_data_out = m_data_reg;
    assign out_free   = !m_valid_reg || m_ready;

    assign idx_nk = (idx_reg == mtks_pkg::IDX_LAST) ? '0 : idx_reg + mtks_pkg::IDX_ONE;
    assign idx_fk = (idx_reg < mtks_pkg::FAR_SPLIT) ? idx_reg + mtks_pkg::FAR_UP
                                                    : idx_reg - mtks_pkg::FAR_SPLIT;

    assign seed_mix  = prev_reg ^ (prev_reg >> 30);
    assign seed_word = prod_reg + 32'(idx_reg);
    assign twisted   = mtks_pkg::twist_one(cur_reg, nxt_reg, rd_a_reg);
    assign tempered  = mtks_pkg::temper(word_reg);

    // read addresses: current and next word first, far word second
    always_comb begin
        rd_a_addr = idx_reg;
        rd_b_addr = idx_nk;
        if (state_reg == S_RD_F) begin
            rd_a_addr = idx_fk;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = twisted;
        unique case (state_reg)
            S_IDLE: begin
                mem_we    = accept && s_start_of_table;
                mem_waddr = '0;
                mem_wdata = table_length_reg + mtks_pkg::SEED_OFFSET;
            end
            S_SEED_ADD: begin
                mem_we    = 1'b1;
                mem_wdata = seed_word;
            end
            S_TWIST: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_length_reg <= '0;
        end else if (cfg_wr_en) begin
            table_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= mtks_pkg::IDX_FULL;
            key_reg     <= mtks_pkg::KEY_START;
            step_reg    <= mtks_pkg::STEP_START;
            m_valid_reg <= 1'b0;
        end else begin
            // S_OUT loads the output register itself
            if (m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        byte_reg <= s_data_in;
                        if (s_start_of_table) begin
                            prev_reg  <= table_length_reg + mtks_pkg::SEED_OFFSET;
                            idx_reg   <= mtks_pkg::IDX_ONE;
                            key_reg   <= mtks_pkg::KEY_START;
                            step_reg  <= mtks_pkg::STEP_START;
                            state_reg <= S_SEED_MUL;
                        end else begin
                            // wrap at the end of the table: start a new twist round
                            if (idx_reg == mtks_pkg::IDX_FULL) begin
                                idx_reg <= '0;
                            end
                            state_reg <= S_RD_CN;
                        end
                    end
                end
                S_SEED_MUL: begin
                    prod_reg  <= seed_mix * mtks_pkg::SEED_MULT;
                    state_reg <= S_SEED_ADD;
                end
                S_SEED_ADD: begin
                    prev_reg <= seed_word;
                    if (idx_reg == mtks_pkg::IDX_LAST) begin
                        idx_reg   <= '0;
                        state_reg <= S_RD_CN;
                    end else begin
                        idx_reg   <= idx_reg + mtks_pkg::IDX_ONE;
                        state_reg <= S_SEED_MUL;
                    end
                end
                S_RD_CN: begin
                    state_reg <= S_RD_F;
                end
                S_RD_F: begin
                    cur_reg   <= rd_a_reg;
                    nxt_reg   <= rd_b_reg;
                    state_reg <= S_TWIST;
                end
                S_TWIST: begin
                    // twist this word in place; later words see it as updated
                    word_reg  <= twisted;
                    idx_reg   <= idx_reg + mtks_pkg::IDX_ONE;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register frees up
                    if (out_free) begin
                        m_data_reg  <= byte_reg ^ tempered[7:0] ^ key_reg;
                        m_valid_reg <= 1'b1;
                        key_reg     <= key_reg + step_reg;
                        step_reg    <= step_reg + mtks_pkg::STEP_GROWTH;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= mtks_pkg::IDX_FULL)
        else $error("word index beyond table");

    a_twist_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TWIST || state_reg == S_SEED_ADD) |-> idx_reg < mtks_pkg::IDX_FULL)
        else $error("state write outside table");

    a_reseed: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_start_of_table |=> state_reg == S_SEED_MUL
                                       && idx_reg == mtks_pkg::IDX_ONE
                                       && key_reg == mtks_pkg::KEY_START)
        else $error("reseed did not start");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT && out_free |=> m_valid_reg && state_reg == S_IDLE)
        else $error("result not loaded");

endmodule

`default_nettype wire

// ===== tb/keystream_checker.sv =====
`timescale 1ns / 100ps
// Checker for the MT19937 keystream byte scrambler: watches the config port and both channels.
// Predicts each result byte and compares it with what comes out. Depends on nothing but its ports.
module keystream_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_data_in,
    input  wire logic        s_start_of_table,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [7:0]  m_data_out,
    output int               fail_count,
    output int               outstanding
);

    localparam int          WORDS       = 624;
    localparam int          FAR_OFFSET  = 397;
    localparam int          REPORT_MAX  = 10;
    localparam logic [31:0] MATRIX_A    = 32'h9908_B0DF;
    localparam logic [31:0] INIT_MULT   = 32'h6C07_8965;
    localparam logic [31:0] SEED_BIAS   = 32'd6;
    localparam logic [31:0] MASK_B      = 32'h9D2C_5680;
    localparam logic [31:0] MASK_C      = 32'hEFC6_0000;
    localparam logic [7:0]  KEY_INIT    = 8'hC5;
    localparam logic [7:0]  STEP_INIT   = 8'h89;
    localparam logic [7:0]  STEP_ADD    = 8'h49;

    logic [31:0] mt_words [WORDS];
    int          mt_pos = WORDS;
    logic [7:0]  key_byte = KEY_INIT;
    logic [7:0]  key_step = STEP_INIT;
    logic [31:0] table_len = '0;
    logic [7:0]  expected_bytes [$];
    logic [7:0]  want_byte;
    int          fails = 0;

    function automatic void reseed(input logic [31:0] seed);
        logic [31:0] p;
        mt_words[0] = seed;
        for (int k = 1; k < WORDS; k++) begin
            p = mt_words[k-1];
            mt_words[k] = (p ^ (p >> 30)) * INIT_MULT + 32'(k);
        end
        mt_pos = WORDS;
    endfunction

    function automatic void regenerate();
        logic [31:0] y;
        int          nk;
        int          fk;
        for (int k = 0; k < WORDS; k++) begin
            nk = (k + 1) % WORDS;
            fk = (k + FAR_OFFSET) % WORDS;
            y = {mt_words[k][31], mt_words[nk][30:0]};
            mt_words[k] = mt_words[fk] ^ (y >> 1) ^ (mt_words[nk][0] ? MATRIX_A : 32'h0);
        end
        mt_pos = 0;
    endfunction

    function automatic logic [31:0] next_word();
        logic [31:0] y;
        if (mt_pos >= WORDS)
            regenerate();
        y = mt_words[mt_pos];
        mt_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MASK_B);
        y = y ^ ((y << 15) & MASK_C);
        return y ^ (y >> 18);
    endfunction

    function automatic logic [7:0] scramble_byte(input logic [7:0] din, input logic sot);
        logic [31:0] w;
        logic [7:0]  r;
        // restart both keystreams before this byte
        if (sot) begin
            reseed(table_len + SEED_BIAS);
            key_byte = KEY_INIT;
            key_step = STEP_INIT;
        end
        w = next_word();
        r = din ^ w[7:0] ^ key_byte;
        key_byte = key_byte + key_step;
        key_step = key_step + STEP_ADD;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (mt_words[i]) mt_words[i] = '0;
            mt_pos = WORDS;
            key_byte = KEY_INIT;
            key_step = STEP_INIT;
            table_len = '0;
            expected_bytes.delete();
            fails = 0;
        end else begin
            if (cfg_wr_en)
                table_len = cfg_wr_data;
            // drain before fill: a result never belongs to an item taken at the same edge
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("%0t: unexpected result byte %02h", $time, m_data_out);
                end else begin
                    want_byte = expected_bytes.pop_front();
                    if (m_data_out !== want_byte) begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display("%0t: data_out mismatch, expected %02h got %02h",
                                     $time, want_byte, m_data_out);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_bytes.push_back(scramble_byte(s_data_in, s_start_of_table));
        end
        fail_count <= fails;
        outstanding <= expected_bytes.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the scrambler testbench: clock, reset, stimulus, result-side stalls and verdict.
// Depends on mt19937_keystream_byte_scrambler and keystream_checker.
module tb_top;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 900;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data_in = '0;
    logic        s_start_of_table = 1'b0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_data_out;

    int fail_count;
    int outstanding;
    int quiet_cycles = 0;
    int sent = 0;
    bit gaps_on = 1'b1;

    mt19937_keystream_byte_scrambler dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_in        (s_data_in),
        .s_start_of_table (s_start_of_table),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data_out       (m_data_out)
    );

    keystream_checker u_chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_in        (s_data_in),
        .s_start_of_table (s_start_of_table),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data_out       (m_data_out),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(30, 80);
    endfunction

    function automatic logic [31:0] pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0;
        else if (r == 1)
            return 32'hFFFF_FFFF;
        else if (r == 2)
            return $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FFF0);
        else
            return $urandom;
    endfunction

    // leaves valid high so a back-to-back item needs no second assignment
    task automatic put_byte(input logic [7:0] b, input logic sot);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_in <= b;
        s_start_of_table <= sot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_len(input logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // result side: bursts of ready broken by stalls
    initial begin
        int run;
        int stall;
        forever begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int  len;
        int  rnd_base;
        bit  first;
        bit  cont;
        bit  sot;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // seed 6, byte extremes, then a restart in the middle of a table
        write_len(32'h0);
        put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h01, 1'b0);
        put_byte(8'h80, 1'b0);
        put_byte(8'h7F, 1'b0);
        put_byte(8'hFE, 1'b0);
        put_byte(8'hFF, 1'b1);
        put_byte(8'h00, 1'b0);
        settle();
        // seed wraps around
        write_len(32'hFFFF_FFFF);
        put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b0);
        settle();
        write_len(32'hFFFF_FFFA);
        put_byte(8'hA5, 1'b1);
        put_byte(8'h5A, 1'b0);
        settle();
        write_len(32'hFFFF_FFF9);
        put_byte(8'h3C, 1'b1);
        settle();
        // new length mid-table: must not matter until the next table start
        write_len(32'h1234_5678);
        put_byte(8'hC3, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h96, 1'b1);
        put_byte(8'h69, 1'b0);
        settle();

        // random tables; the first one has more items than a generator block, though random restarts may split it
        rnd_base = sent;
        first = 1'b1;
        while (sent - rnd_base < RANDOM_ITEMS) begin
            write_len(pick_len());
            gaps_on = ($urandom_range(0, 9) >= 3);
            len = (first || $urandom_range(0, 11) == 0) ? $urandom_range(625, 720)
                                                        : $urandom_range(1, 40);
            // stop near the item budget
            if (len > RANDOM_ITEMS - (sent - rnd_base))
                len = RANDOM_ITEMS - (sent - rnd_base);
            cont = !first && ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len; i++) begin
                sot = (i == 0 && !cont) || ($urandom_range(0, 99) < 2);
                put_byte(8'($urandom_range(0, 255)), sot);
            end
            settle();
            first = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
